[rtl/fs20_frame_transmitter_macros.svh]
// ----------------------------------------------------------------------------
// FS20 frame transmitter assertion macros
// Shared property wrappers clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FS20_FRAME_TRANSMITTER_MACROS_SVH
`define FS20_FRAME_TRANSMITTER_MACROS_SVH

// Same-cycle implication
`define FS20_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define FS20_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/fs20tx_pkg.sv]
// ----------------------------------------------------------------------------
// FS20 transmitter package
// Word types, phase encoding, opcodes, register indexes and telegram constants.
// ----------------------------------------------------------------------------
package fs20tx_pkg;

    // Input word
    typedef struct packed {
        logic        op;
        logic [15:0] house_code;
        logic [7:0]  unit_address;
        logic [7:0]  command_byte;
        logic        ext_present;
        logic [7:0]  ext_value;
    } fs20tx_in_t;

    // Result word
    typedef struct packed {
        logic pin;
        logic busy_res;
        logic accepted;
        logic done_res;
    } fs20tx_out_t;

    // Telegram phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_SYNC  = 5'b00010,
        PH_DATA  = 5'b00100,
        PH_TRAIL = 5'b01000,
        PH_GAP   = 5'b10000
    } fs20tx_phase_t;

    // Opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HALF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HALF  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP       = 2'd2;

    // Register reset values
    localparam logic [15:0] ZERO_HALF_RST = 16'd400;
    localparam logic [15:0] ONE_HALF_RST  = 16'd600;
    localparam logic [15:0] GAP_RST       = 16'd10000;

    // Telegram constants
    localparam logic [7:0] CHK_BIAS     = 8'd6;
    localparam logic [7:0] CMD_DIM_UP   = 8'd19;
    localparam logic [7:0] CMD_DIM_DOWN = 8'd20;
    localparam logic [1:0] REP_SHORT    = 2'd2;
    localparam logic [1:0] REP_LONG     = 2'd3;
    localparam logic [2:0] BYTES_PLAIN  = 3'd5;
    localparam logic [2:0] BYTES_EXT    = 3'd6;
    localparam logic [3:0] DATA_BITS    = 4'd8;

endpackage

[rtl/fs20_frame_transmitter.sv]
// ----------------------------------------------------------------------------
// FS20 frame transmitter
// Pulse-width encoder for one FS20 telegram: sync, data bytes with even
// parity, checksum, trailing zero and gap, repeated two or three times.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------
//  in       | in_valid / in_stall  | in_data  (fs20tx_in_t)
//  out      | out_valid / out_stall| out_data (fs20tx_out_t)
//  cfg      | cfg_wr_en            | cfg_index, cfg_data
//
//  Every input word is handled at its accepting edge: the sequencer state and the result
//  register both update at that edge, so one word enters per clock while in_stall is low.
//  The result of a word is on out_data the cycle after it is accepted.
//  in_stall follows out_stall only while the result register is full.
//  Reset returns the sequencer to idle and loads the default tick counts.
//
`include "fs20_frame_transmitter_macros.svh"

module fs20_frame_transmitter
    import fs20tx_pkg::*;
#(
    parameter int unsigned SYNC_ZEROS = 12
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  fs20tx_in_t           in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output fs20tx_out_t          out_data,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    localparam logic [3:0] SYNC_LAST = 4'(SYNC_ZEROS);

    // Configuration
    logic [15:0] zero_half_reg;
    logic [15:0] one_half_reg;
    logic [15:0] gap_reg;

    // Telegram fields
    logic [15:0] house_reg,    house_next;
    logic [7:0]  addr_reg,     addr_next;
    logic [7:0]  cmd_reg,      cmd_next;
    logic [7:0]  ext_reg,      ext_next;
    logic        ext_flag_reg, ext_flag_next;
    logic [7:0]  chk_reg,      chk_next;

    // Sequencer
    fs20tx_phase_t phase_reg,   phase_next;
    logic [1:0]    repeats_reg, repeats_next;
    logic [3:0]    bit_pos_reg, bit_pos_next;
    logic [2:0]    byte_pos_reg, byte_pos_next;
    logic          half_reg,    half_next;
    logic [15:0]   tick_reg,    tick_next;
    logic          line_reg,    line_next;

    // Result register
    logic        out_valid_reg;
    fs20tx_out_t out_data_reg;

    logic        in_fire;
    logic        out_fire;
    logic [7:0]  cur_byte;
    logic        sym_bit;
    logic [15:0] half_len;
    logic [15:0] tick_inc;
    logic [2:0]  byte_pos_inc;
    logic [2:0]  byte_total;
    logic [7:0]  start_chk;
    logic        end_rep;
    logic        accepted;
    logic        done;

    assign in_stall  = out_valid_reg & out_stall;
    assign in_fire   = in_valid & ~in_stall;
    assign out_fire  = out_valid_reg & ~out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_half_reg <= ZERO_HALF_RST;
            one_half_reg  <= ONE_HALF_RST;
            gap_reg       <= GAP_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_ZERO_HALF: zero_half_reg <= cfg_data;
                REG_ONE_HALF:  one_half_reg  <= cfg_data;
                REG_GAP:       gap_reg       <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Select the byte under transmission
    always_comb
    begin
        case (byte_pos_reg)
            3'd0:    cur_byte = house_reg[15:8];
            3'd1:    cur_byte = house_reg[7:0];
            3'd2:    cur_byte = addr_reg;
            3'd3:    cur_byte = cmd_reg;
            3'd4:    cur_byte = ext_flag_reg ? ext_reg : chk_reg;
            default: cur_byte = chk_reg;
        endcase
    end

    // Current symbol value: sync zeros ending in a one, data bits MSB first, then even parity
    always_comb
    begin
        if (phase_reg == PH_SYNC)
        begin
            sym_bit = (bit_pos_reg >= SYNC_LAST);
        end
        else if (phase_reg == PH_DATA)
        begin
            if (bit_pos_reg < DATA_BITS)
            begin
                sym_bit = cur_byte[~bit_pos_reg[2:0]];
            end
            else
            begin
                sym_bit = ^cur_byte;
            end
        end
        else
        begin
            sym_bit = 1'b0;
        end
    end

    assign half_len     = sym_bit ? one_half_reg : zero_half_reg;
    assign tick_inc     = tick_reg + 16'd1;
    assign byte_pos_inc = byte_pos_reg + 3'd1;
    assign byte_total   = ext_flag_reg ? BYTES_EXT : BYTES_PLAIN;
    assign start_chk    = 8'(CHK_BIAS + in_data.house_code[15:8] + in_data.house_code[7:0]
                            + in_data.unit_address + in_data.command_byte
                            + (in_data.ext_present ? in_data.ext_value : 8'd0));

    // Next state of the sequencer
    always_comb
    begin
        house_next    = house_reg;
        addr_next     = addr_reg;
        cmd_next      = cmd_reg;
        ext_next      = ext_reg;
        ext_flag_next = ext_flag_reg;
        chk_next      = chk_reg;
        phase_next    = phase_reg;
        repeats_next  = repeats_reg;
        bit_pos_next  = bit_pos_reg;
        byte_pos_next = byte_pos_reg;
        half_next     = half_reg;
        tick_next     = tick_reg;
        line_next     = line_reg;
        end_rep       = 1'b0;
        accepted      = 1'b0;
        done          = 1'b0;

        if (in_fire)
        begin
            if (in_data.op == OP_START)
            begin
                // Load a telegram only when idle
                if (phase_reg == PH_IDLE)
                begin
                    house_next    = in_data.house_code;
                    addr_next     = in_data.unit_address;
                    cmd_next      = in_data.command_byte;
                    ext_next      = in_data.ext_value;
                    ext_flag_next = in_data.ext_present;
                    chk_next      = start_chk;
                    repeats_next  = (!in_data.ext_present &&
                                     (in_data.command_byte == CMD_DIM_UP ||
                                      in_data.command_byte == CMD_DIM_DOWN))
                                    ? REP_SHORT : REP_LONG;
                    phase_next    = PH_SYNC;
                    bit_pos_next  = 4'd0;
                    byte_pos_next = 3'd0;
                    half_next     = 1'b0;
                    tick_next     = 16'd0;
                    line_next     = 1'b0;
                    accepted      = 1'b1;
                end
            end
            else if (phase_reg == PH_GAP)
            begin
                // Count the low gap
                line_next = 1'b0;
                tick_next = tick_inc;
                if (tick_inc >= gap_reg || tick_inc == 16'd0)
                begin
                    end_rep = 1'b1;
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                // Drive one half of the current symbol; a zero length counts as one
                line_next = ~half_reg;
                tick_next = tick_inc;
                if (tick_inc >= half_len || tick_inc == 16'd0)
                begin
                    tick_next = 16'd0;
                    if (!half_reg)
                    begin
                        half_next = 1'b1;
                    end
                    else
                    begin
                        half_next = 1'b0;
                        // Advance to the next symbol
                        if (phase_reg == PH_SYNC)
                        begin
                            if (bit_pos_reg < SYNC_LAST)
                            begin
                                bit_pos_next = bit_pos_reg + 4'd1;
                            end
                            else
                            begin
                                phase_next    = PH_DATA;
                                byte_pos_next = 3'd0;
                                bit_pos_next  = 4'd0;
                            end
                        end
                        else if (phase_reg == PH_DATA)
                        begin
                            if (bit_pos_reg < DATA_BITS)
                            begin
                                bit_pos_next = bit_pos_reg + 4'd1;
                            end
                            else
                            begin
                                bit_pos_next  = 4'd0;
                                byte_pos_next = byte_pos_inc;
                                if (byte_pos_inc >= byte_total)
                                begin
                                    phase_next = PH_TRAIL;
                                end
                            end
                        end
                        else
                        begin
                            phase_next = PH_GAP;
                            if (gap_reg == 16'd0)
                            begin
                                end_rep = 1'b1;
                            end
                        end
                    end
                end
            end

            // Close a repeat: restart or finish the telegram
            if (end_rep)
            begin
                bit_pos_next  = 4'd0;
                byte_pos_next = 3'd0;
                half_next     = 1'b0;
                tick_next     = 16'd0;
                if (repeats_reg <= 2'd1)
                begin
                    repeats_next = 2'd0;
                    phase_next   = PH_IDLE;
                    line_next    = 1'b0;
                    done         = 1'b1;
                end
                else
                begin
                    repeats_next = repeats_reg - 2'd1;
                    phase_next   = PH_SYNC;
                end
            end
        end
    end

    // Telegram fields hold their contents until the next start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            house_reg    <= 16'd0;
            addr_reg     <= 8'd0;
            cmd_reg      <= 8'd0;
            ext_reg      <= 8'd0;
            ext_flag_reg <= 1'b0;
            chk_reg      <= 8'd0;
        end
        else
        begin
            house_reg    <= house_next;
            addr_reg     <= addr_next;
            cmd_reg      <= cmd_next;
            ext_reg      <= ext_next;
            ext_flag_reg <= ext_flag_next;
            chk_reg      <= chk_next;
        end
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            repeats_reg  <= 2'd0;
            bit_pos_reg  <= 4'd0;
            byte_pos_reg <= 3'd0;
            half_reg     <= 1'b0;
            tick_reg     <= 16'd0;
            line_reg     <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            repeats_reg  <= repeats_next;
            bit_pos_reg  <= bit_pos_next;
            byte_pos_reg <= byte_pos_next;
            half_reg     <= half_next;
            tick_reg     <= tick_next;
            line_reg     <= line_next;
        end
    end

    // Result word valid: set on accept, clear when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result word payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg.pin      <= line_next;
            out_data_reg.busy_res <= (phase_next != PH_IDLE);
            out_data_reg.accepted <= accepted;
            out_data_reg.done_res <= done;
        end
    end

    // Checks
    `FS20_ASSERT_NEXT(a_busy_start_refused,
        in_fire && in_data.op == OP_START && phase_reg != PH_IDLE,
        !out_data_reg.accepted, "start word taken while a telegram was running")
    `FS20_ASSERT_NOW(a_done_ends_telegram,
        out_valid_reg && out_data_reg.done_res,
        !out_data_reg.busy_res && !out_data_reg.pin, "done reported with line busy or high")
    `FS20_ASSERT_NOW(a_idle_line_low,
        phase_reg == PH_IDLE, !line_reg && repeats_reg == 2'd0, "line active while idle")

endmodule
